// ===== src/skybox_texel_address_defines.svh =====
// assertion macros shared by the skybox texel address rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef SKYBOX_TEXEL_ADDRESS_DEFINES_SVH
`define SKYBOX_TEXEL_ADDRESS_DEFINES_SVH

// consequence must hold in the same cycle
`define SKYA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("skybox texel address: same cycle check failed");

// consequence must hold in the next cycle
`define SKYA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("skybox texel address: next cycle check failed");

`endif

// ===== src/skya_pkg.sv =====
// types, codes and the sine series shared by the skybox texel address block
// no dependencies
package skya_pkg;

	localparam int CFG_DATA_W = 17;
	localparam int DIV_NUM_W  = 34;
	localparam int DIV_DEN_W  = 18;
	localparam int DIV_Q_W    = 17;
	localparam int DIV_LANES  = 2;
	localparam int LANE_U     = 0;
	localparam int LANE_V     = 1;

	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

	typedef enum logic [2:0] {
		REG_SKYBOX_ENABLED    = 3'd0,
		REG_FACE_PRESENT_MASK = 3'd1,
		REG_SCREEN_WIDTH      = 3'd2,
		REG_HORIZON_ROW       = 3'd3,
		REG_PROJECTION_SCALE  = 3'd4,
		REG_TEXTURE_WIDTH     = 3'd5,
		REG_TEXTURE_HEIGHT    = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		FACE_FLOOR   = 3'd0,
		FACE_CEILING = 3'd1,
		FACE_BACK    = 3'd2,
		FACE_LEFT    = 3'd3,
		FACE_FRONT   = 3'd4,
		FACE_RIGHT   = 3'd5
	} face_t;

	typedef struct packed {
		logic [11:0] pixel_column;
		logic [11:0] pixel_row;
		logic [15:0] view_angle;
	} pix_in_t;

	typedef struct packed {
		logic [23:0] frame_address;
		logic [2:0]  texel_face;
		logic [9:0]  texel_x;
		logic [9:0]  texel_y;
		logic        texel_present;
	} texel_out_t;

	typedef struct packed {
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_op_t;

	typedef struct packed {
		logic [DIV_Q_W-1:0] q;
		logic               ovf;
	} div_quo_t;

	// what rides along the divider next to the operands
	typedef struct packed {
		face_t       face;
		logic        plane;
		logic        neg_x;
		logic        neg_y;
		logic        v_zero;
		logic [23:0] frame_address;
	} side_t;

	// sin of a 16-bit binary angle in Q1.14, quadrant fold and series to x^11
	function automatic logic signed [15:0] sine_q14(input logic [15:0] phase);
		logic [1:0] quad;
		longint unsigned r, x, x2, term;
		longint sum, val;
		quad = phase[15:14];
		r    = 64'(phase[13:0]);
		if (quad[0]) r = 64'd16384 - r;
		x    = (r * TWO_PI_Q30 + 64'd32768) >> 16;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - longint'(term);
		if (sum < 0) sum = 0;
		val = (sum + 32768) >>> 16;
		if (val > 16384) val = 16384;
		return (quad[1]) ? 16'(-val) : 16'(val);
	endfunction

endpackage

// ===== src/skya_div.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage
// depends on skya_pkg for operand, quotient and sideband types
module skya_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  skya_pkg::side_t    in_side,
	input  skya_pkg::div_op_t  op [skya_pkg::DIV_LANES],
	output logic               out_valid,
	output skya_pkg::side_t    out_side,
	output skya_pkg::div_quo_t quo [skya_pkg::DIV_LANES]
);

	localparam int NUM_W  = skya_pkg::DIV_NUM_W;
	localparam int DEN_W  = skya_pkg::DIV_DEN_W;
	localparam int Q_W    = skya_pkg::DIV_Q_W;
	localparam int LANES  = skya_pkg::DIV_LANES;
	localparam int DEXT_W = NUM_W + 1;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [Q_W-1:0]   q;
		logic             ovf;
	} lane_t;

	lane_t           lane_s  [Q_W+1][LANES];
	logic            valid_s [Q_W+1];
	skya_pkg::side_t side_s  [Q_W+1];

	// entry stage: quotient of 2^Q_W or more is flagged and saturated later
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_entry
		always_ff @(posedge clk) begin
			if (en) begin
				lane_s[0][l].rem <= op[l].num;
				lane_s[0][l].den <= op[l].den;
				lane_s[0][l].q   <= '0;
				lane_s[0][l].ovf <= {1'b0, op[l].num} >= (DEXT_W'(op[l].den) << Q_W);
			end
		end
	end

	for (genvar j = 1; j <= Q_W; j++) begin : g_stage
		localparam int BIT = Q_W - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (en) begin
				valid_s[j] <= valid_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j] <= side_s[j-1];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DEXT_W-1:0] shifted;
			logic              ge;
			lane_t             nxt;

			always_comb begin
				shifted    = DEXT_W'(lane_s[j-1][l].den) << BIT;
				ge         = {1'b0, lane_s[j-1][l].rem} >= shifted;
				nxt        = lane_s[j-1][l];
				nxt.q[BIT] = ge;
				if (ge) begin
					nxt.rem = lane_s[j-1][l].rem - shifted[NUM_W-1:0];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					lane_s[j][l] <= nxt;
				end
			end
		end
	end

	assign out_valid = valid_s[Q_W];
	assign out_side  = side_s[Q_W];

	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign quo[l].q   = lane_s[Q_W][l].q;
		assign quo[l].ovf = lane_s[Q_W][l].ovf;
	end

endmodule

// ===== src/skybox_texel_address.sv =====
// skybox texel address top level: sine rom, face pick, divider, texel scale
// depends on skya_pkg, skya_div and skybox_texel_address_defines.svh
//
//   channel | signals                              | transfer when
//   --------+--------------------------------------+--------------------------
//   pixel   | in_valid, in_ready, in_data          | in_valid & in_ready
//   texel   | out_valid, out_ready, out_data       | out_valid & out_ready
//   config  | cfg_valid, cfg_ready, cfg_index/data | cfg_valid & cfg_ready
//
// one pixel per clock while in_ready is high; a result passes 23 registers in line on its
// way to out_valid: the 17 quotient-bit stages of the divider plus six around it.
// reset clears valid bits and loads the register defaults; no clearing pass.
// an output register plus one skid entry take results while out_ready is low;
// the whole pipe holds only once the skid entry is full.
// pixels taken while the skybox is disabled are dropped and give no result.
`include "skybox_texel_address_defines.svh"

module skybox_texel_address #(
	parameter int SINE_TABLE_ENTRIES = 1024,
	parameter int MAX_TEXTURE_DIM    = 1024,
	parameter int MAX_SCREEN_DIM     = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  skya_pkg::pix_in_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output skya_pkg::texel_out_t          out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [skya_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);

	// ---------------- configuration registers
	logic               skybox_enabled_q;
	logic [5:0]         face_present_mask_q;
	logic [12:0]        screen_width_q;
	logic signed [16:0] horizon_row_q;
	logic [15:0]        projection_scale_q;
	logic [10:0]        texture_width_q;
	logic [10:0]        texture_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skybox_enabled_q    <= 1'b0;
			face_present_mask_q <= 6'd0;
			screen_width_q      <= 13'd640;
			horizon_row_q       <= 17'sd3840;
			projection_scale_q  <= 16'd5120;
			texture_width_q     <= 11'd256;
			texture_height_q    <= 11'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				skya_pkg::REG_SKYBOX_ENABLED:    skybox_enabled_q    <= cfg_data[0];
				skya_pkg::REG_FACE_PRESENT_MASK: face_present_mask_q <= cfg_data[5:0];
				skya_pkg::REG_SCREEN_WIDTH:      screen_width_q      <= cfg_data[12:0];
				skya_pkg::REG_HORIZON_ROW:       horizon_row_q       <= cfg_data[16:0];
				skya_pkg::REG_PROJECTION_SCALE:  projection_scale_q  <= cfg_data[15:0];
				skya_pkg::REG_TEXTURE_WIDTH:     texture_width_q     <= cfg_data[10:0];
				skya_pkg::REG_TEXTURE_HEIGHT:    texture_height_q    <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipeline enable and output skid
	logic                 en;
	logic                 out_valid_q;
	logic                 skid_v_q;
	skya_pkg::texel_out_t head_q;
	skya_pkg::texel_out_t skid_q;

	assign en       = !skid_v_q;
	assign in_ready = en;

	// ---------------- stage 1: sine rom lookup
	logic signed [15:0] sine_rom [SINE_TABLE_ENTRIES];

	for (genvar gi = 0; gi < SINE_TABLE_ENTRIES; gi++) begin : g_rom
		localparam int PHASE = (gi * 65536) / SINE_TABLE_ENTRIES;
		assign sine_rom[gi] = skya_pkg::sine_q14(16'(PHASE));
	end

	logic [15:0]        ang_cos;
	logic [IDX_W+16:0]  prod_sin, prod_cos;
	logic [IDX_W-1:0]   idx_sin, idx_cos;

	assign ang_cos  = in_data.view_angle + 16'd16384;
	assign prod_sin = (IDX_W+17)'(in_data.view_angle) * (IDX_W+17)'(SINE_TABLE_ENTRIES);
	assign prod_cos = (IDX_W+17)'(ang_cos) * (IDX_W+17)'(SINE_TABLE_ENTRIES);
	assign idx_sin  = prod_sin[16 +: IDX_W];
	assign idx_cos  = prod_cos[16 +: IDX_W];

	logic               valid_s1;
	logic signed [15:0] dx_s1, dy_s1;
	logic [11:0]        col_s1, row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid && skybox_enabled_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dy_s1  <= sine_rom[idx_sin];
			dx_s1  <= sine_rom[idx_cos];
			col_s1 <= in_data.pixel_column;
			row_s1 <= in_data.pixel_row;
		end
	end

	// ---------------- stage 2: side face, u numerator, band half height
	logic [14:0]        adx_b, ady_b, ad_b;
	logic signed [16:0] dx17_b, dy17_b, ad17_b, num17_b;
	skya_pkg::face_t    face_b;
	logic [30:0]        pprod_b;
	logic [12:0]        sw_eff;
	logic [24:0]        fprod_b;

	always_comb begin
		adx_b  = dx_s1[15] ? 15'(-dx_s1) : dx_s1[14:0];
		ady_b  = dy_s1[15] ? 15'(-dy_s1) : dy_s1[14:0];
		dx17_b = dx_s1;
		dy17_b = dy_s1;
		if (adx_b >= ady_b) begin
			ad_b   = (adx_b == 15'd0) ? 15'd1 : adx_b;
			ad17_b = {2'b00, ad_b};
			if (dx_s1 > 16'sd0) begin
				face_b  = skya_pkg::FACE_RIGHT;
				num17_b = ad17_b + dy17_b;
			end else begin
				face_b  = skya_pkg::FACE_LEFT;
				num17_b = ad17_b - dy17_b;
			end
		end else begin
			ad_b   = ady_b;
			ad17_b = {2'b00, ad_b};
			if (dy_s1 > 16'sd0) begin
				face_b  = skya_pkg::FACE_BACK;
				num17_b = ad17_b - dx17_b;
			end else begin
				face_b  = skya_pkg::FACE_FRONT;
				num17_b = ad17_b + dx17_b;
			end
		end
	end

	assign pprod_b = 31'(ad_b) * 31'(projection_scale_q);
	assign sw_eff  = (32'(screen_width_q) > MAX_SCREEN_DIM) ? 13'(MAX_SCREEN_DIM)
		: screen_width_q;
	assign fprod_b = 25'(row_s1) * 25'(sw_eff) + 25'(col_s1);

	logic               valid_s2;
	skya_pkg::face_t    face_s2;
	logic [15:0]        num_s2;
	logic [14:0]        ad_s2;
	logic [16:0]        p_s2;
	logic signed [15:0] dx_s2, dy_s2;
	logic [11:0]        row_s2;
	logic [23:0]        fa_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			face_s2 <= face_b;
			num_s2  <= num17_b[15:0];
			ad_s2   <= ad_b;
			p_s2    <= pprod_b[30:14];
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			row_s2  <= row_s1;
			fa_s2   <= fprod_b[23:0];
		end
	end

	// ---------------- stage 3: horizon band, plane distance, plane numerators
	logic signed [18:0] h19_c, p19_c, ys19_c, top_c, bot_c, dys_c, numv_c;
	logic               ceil_c, floor_c;
	logic [17:0]        m_c;
	logic [14:0]        adx_c, ady_c;
	logic [30:0]        prodx_c, prody_c;
	skya_pkg::face_t    face_c;

	always_comb begin
		h19_c   = {{2{horizon_row_q[16]}}, horizon_row_q};
		p19_c   = {2'b00, p_s2};
		ys19_c  = {3'b000, row_s2, 4'b0000};
		top_c   = h19_c - p19_c;
		bot_c   = h19_c + p19_c;
		dys_c   = ys19_c - h19_c;
		numv_c  = ys19_c - top_c;
		ceil_c  = (ys19_c + 19'sd16) <= top_c;
		floor_c = ys19_c > bot_c;
		if (ceil_c) begin
			face_c = skya_pkg::FACE_CEILING;
			m_c    = (dys_c > -19'sd1) ? 18'd1 : 18'(-dys_c);
		end else if (floor_c) begin
			face_c = skya_pkg::FACE_FLOOR;
			m_c    = (dys_c < 19'sd1) ? 18'd1 : 18'(dys_c);
		end else begin
			face_c = face_s2;
			m_c    = 18'd1;
		end
	end

	assign adx_c   = dx_s2[15] ? 15'(-dx_s2) : dx_s2[14:0];
	assign ady_c   = dy_s2[15] ? 15'(-dy_s2) : dy_s2[14:0];
	assign prodx_c = 31'(adx_c) * 31'(projection_scale_q);
	assign prody_c = 31'(ady_c) * 31'(projection_scale_q);

	logic            valid_s3;
	skya_pkg::face_t face_s3;
	logic            plane_s3, neg_x_s3, neg_y_s3, v_zero_s3;
	logic [17:0]     m_s3, num_v_s3;
	logic [15:0]     num_u_s3;
	logic [14:0]     ad_s3;
	logic [16:0]     p_s3;
	logic [30:0]     prod_x_s3, prod_y_s3;
	logic [23:0]     fa_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			face_s3   <= face_c;
			plane_s3  <= ceil_c || floor_c;
			neg_x_s3  <= dx_s2[15];
			neg_y_s3  <= dy_s2[15];
			v_zero_s3 <= (p_s2 == 17'd0) || (numv_c <= 19'sd0);
			m_s3      <= m_c;
			num_v_s3  <= numv_c[17:0];
			num_u_s3  <= num_s2;
			ad_s3     <= ad_s2;
			p_s3      <= p_s2;
			prod_x_s3 <= prodx_c;
			prod_y_s3 <= prody_c;
			fa_s3     <= fa_s2;
		end
	end

	// ---------------- divider
	skya_pkg::div_op_t  div_op  [skya_pkg::DIV_LANES];
	skya_pkg::div_quo_t div_quo [skya_pkg::DIV_LANES];
	skya_pkg::side_t    div_side_in, div_side_out;
	logic               div_valid;

	always_comb begin
		if (plane_s3) begin
			div_op[skya_pkg::LANE_U].num = {2'b00, prod_x_s3, 1'b0};
			div_op[skya_pkg::LANE_U].den = m_s3;
			div_op[skya_pkg::LANE_V].num = {2'b00, prod_y_s3, 1'b0};
			div_op[skya_pkg::LANE_V].den = m_s3;
		end else begin
			div_op[skya_pkg::LANE_U].num = {3'b000, num_u_s3, 15'd0};
			div_op[skya_pkg::LANE_U].den = {3'b000, ad_s3};
			div_op[skya_pkg::LANE_V].num = {num_v_s3, 16'd0};
			div_op[skya_pkg::LANE_V].den = {p_s3, 1'b0};
		end
		div_side_in.face          = face_s3;
		div_side_in.plane         = plane_s3;
		div_side_in.neg_x         = neg_x_s3;
		div_side_in.neg_y         = neg_y_s3;
		div_side_in.v_zero        = v_zero_s3;
		div_side_in.frame_address = fa_s3;
	end

	skya_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_side   (div_side_in),
		.op        (div_op),
		.out_valid (div_valid),
		.out_side  (div_side_out),
		.quo       (div_quo)
	);

	// ---------------- stage 4: saturate, plane offset, present flag
	function automatic logic [16:0] sat_q(input skya_pkg::div_quo_t d);
		return (d.ovf || d.q > 17'd65536) ? 17'd65536 : d.q;
	endfunction

	function automatic logic [16:0] plane_coord(input logic [16:0] qs, input logic neg);
		logic [17:0] c;
		if (neg) begin
			c = 18'd32768 - 18'(qs);
			return c[17] ? 17'd0 : c[16:0];
		end
		c = 18'd32768 + 18'(qs);
		return (c > 18'd65536) ? 17'd65536 : c[16:0];
	endfunction

	logic [16:0] qu_d, qv_d, fu_d, fv_d;

	always_comb begin
		qu_d = sat_q(div_quo[skya_pkg::LANE_U]);
		qv_d = sat_q(div_quo[skya_pkg::LANE_V]);
		if (div_side_out.plane) begin
			fu_d = plane_coord(qu_d, div_side_out.neg_x);
			fv_d = plane_coord(qv_d, div_side_out.neg_y);
		end else begin
			fu_d = qu_d;
			fv_d = div_side_out.v_zero ? 17'd0 : qv_d;
		end
	end

	logic            valid_s4;
	skya_pkg::face_t face_s4;
	logic [16:0]     fu_s4, fv_s4;
	logic            present_s4;
	logic [23:0]     fa_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			face_s4    <= div_side_out.face;
			fu_s4      <= fu_d;
			fv_s4      <= fv_d;
			present_s4 <= face_present_mask_q[div_side_out.face];
			fa_s4      <= div_side_out.frame_address;
		end
	end

	// ---------------- texel scale into the output register
	function automatic logic [9:0] to_texel(input logic [16:0] f, input logic [10:0] dim);
		logic [10:0] d, mx;
		logic [27:0] prod;
		d    = (32'(dim) > MAX_TEXTURE_DIM) ? 11'(MAX_TEXTURE_DIM) : dim;
		mx   = (d == 11'd0) ? 11'd0 : d - 11'd1;
		prod = 28'(f) * 28'(mx);
		return prod[25:16];
	endfunction

	skya_pkg::texel_out_t res_c;

	always_comb begin
		res_c.frame_address = fa_s4;
		res_c.texel_face    = face_s4;
		res_c.texel_present = present_s4;
		res_c.texel_x       = present_s4 ? to_texel(fu_s4, texture_width_q) : 10'd0;
		res_c.texel_y       = present_s4 ? to_texel(fv_s4, texture_height_q) : 10'd0;
	end

	logic pop, push;

	assign pop  = out_valid_q && out_ready;
	assign push = valid_s4 && en;

	// skid entry is always the younger result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q <= skid_v_q || push;
			skid_v_q    <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			head_q <= skid_v_q ? skid_q : res_c;
		end
		if (push) begin
			skid_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = head_q;

	`SKYA_ASSERT_NOW(a_skid_behind_head, skid_v_q, out_valid_q)
	`SKYA_ASSERT_NEXT(a_stalled_result_parked,
		valid_s4 && out_valid_q && !out_ready && !skid_v_q, skid_v_q)
	`SKYA_ASSERT_NEXT(a_disabled_dropped,
		in_valid && in_ready && !skybox_enabled_q, !valid_s1)
	`SKYA_ASSERT_NOW(a_absent_face_zero,
		out_valid_q && !out_data.texel_present,
		out_data.texel_x == 10'd0 && out_data.texel_y == 10'd0)

endmodule

// ===== bench/skybox_texel_address_checker.sv =====
// checker for the skybox texel address block: watches config, pixel and texel channels,
// predicts each texel from its own register copy and compares field by field
// depends on skya_pkg
module skybox_texel_address_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  skya_pkg::pix_in_t               in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  skya_pkg::texel_out_t            out_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [2:0]                      cfg_index,
	input  logic [skya_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              failures,
	output int                              texels_waiting,
	output int                              pixels_taken,
	output int                              texels_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ROM_ENTRIES = 1024;
	localparam longint TEX_MAX     = 1024;
	localparam longint SCREEN_MAX  = 4096;
	localparam longint ANGLE_STEP  = 64'd6746518852;

	logic        sky_on;
	logic [5:0]  face_mask;
	logic [12:0] row_pitch;
	longint      horizon_q4;
	longint      proj_scale;
	logic [10:0] tex_w;
	logic [10:0] tex_h;

	skya_pkg::texel_out_t texel_due[$];

	// Q1.14 sine of a binary angle via the rom index and a series to x^11
	function automatic longint sine_q14_of(input logic [15:0] angle);
		longint idx, phase, r, x, x2, term, acc, val;
		logic [1:0] quad;
		idx   = (longint'(angle) * ROM_ENTRIES) >> 16;
		phase = ((idx * 65536) / ROM_ENTRIES) & 64'hFFFF;
		quad  = phase[15:14];
		r     = phase & 64'h3FFF;
		if (quad[0]) r = 16384 - r;
		x    = (r * ANGLE_STEP + 32768) >> 16;
		x2   = (x * x) >> 30;
		term = x;
		acc  = x;
		for (int k = 1; k <= 5; k++) begin
			term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
			if (k % 2 == 1) acc = acc - term;
			else acc = acc + term;
		end
		if (acc < 0) acc = 0;
		val = (acc + 32768) >>> 16;
		if (val > 16384) val = 16384;
		return quad[1] ? -val : val;
	endfunction

	function automatic longint plane_uv(input longint dir, input longint plane_m);
		longint mag, q, c;
		mag = dir < 0 ? -dir : dir;
		q   = (2 * mag * proj_scale) / plane_m;
		if (q > 65536) q = 65536;
		c = dir < 0 ? 32768 - q : 32768 + q;
		if (c < 0) c = 0;
		if (c > 65536) c = 65536;
		return c;
	endfunction

	function automatic logic [9:0] texel_coord(input longint f, input longint dim);
		longint d, mx, t;
		d  = dim > TEX_MAX ? TEX_MAX : dim;
		mx = d != 0 ? d - 1 : 0;
		if (f < 0) f = 0;
		if (f > 65536) f = 65536;
		t = (f * mx) >> 16;
		if (t > mx) t = mx;
		return t[9:0];
	endfunction

	function automatic skya_pkg::texel_out_t texel_for_pixel(input skya_pkg::pix_in_t px);
		skya_pkg::texel_out_t res;
		longint dx, dy, adx, ady, ad, num, u, v, p, top, bot, ys, plane_m, sw;
		skya_pkg::face_t face;
		dy  = sine_q14_of(px.view_angle);
		dx  = sine_q14_of(px.view_angle + 16'd16384);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		if (adx >= ady) begin
			ad = adx != 0 ? adx : 1;
			if (dx > 0) begin
				face = skya_pkg::FACE_RIGHT;
				num  = ad + dy;
			end else begin
				face = skya_pkg::FACE_LEFT;
				num  = ad - dy;
			end
		end else begin
			ad = ady;
			if (dy > 0) begin
				face = skya_pkg::FACE_BACK;
				num  = ad - dx;
			end else begin
				face = skya_pkg::FACE_FRONT;
				num  = ad + dx;
			end
		end
		u   = (num * 32768) / ad;
		p   = (ad * proj_scale) >> 14;
		top = horizon_q4 - p;
		bot = horizon_q4 + p;
		ys  = longint'(px.pixel_row) * 16;
		if (ys + 16 <= top) begin
			face    = skya_pkg::FACE_CEILING;
			plane_m = horizon_q4 - ys;
			if (plane_m < 1) plane_m = 1;
			u = plane_uv(dx, plane_m);
			v = plane_uv(dy, plane_m);
		end else if (ys > bot) begin
			face    = skya_pkg::FACE_FLOOR;
			plane_m = ys - horizon_q4;
			if (plane_m < 1) plane_m = 1;
			u = plane_uv(dx, plane_m);
			v = plane_uv(dy, plane_m);
		end else begin
			num = ys - top;
			if (p == 0 || num <= 0) v = 0;
			else v = (num * 65536) / (2 * p);
			if (v > 65536) v = 65536;
		end
		res = '0;
		res.texel_face    = face;
		res.texel_present = face_mask[face];
		if (res.texel_present) begin
			res.texel_x = texel_coord(u, longint'(tex_w));
			res.texel_y = texel_coord(v, longint'(tex_h));
		end
		sw = row_pitch > SCREEN_MAX ? SCREEN_MAX : longint'(row_pitch);
		res.frame_address = 24'(longint'(px.pixel_row) * sw + longint'(px.pixel_column));
		return res;
	endfunction

	task automatic note_failure(input string what, input skya_pkg::texel_out_t want,
		input skya_pkg::texel_out_t got);
		failures++;
		if (failures <= 10) begin
			$display("%0t %s: expected addr %0d face %0d x %0d y %0d present %0d",
				$realtime, what, want.frame_address, want.texel_face, want.texel_x,
				want.texel_y, want.texel_present);
			$display("    got addr %0d face %0d x %0d y %0d present %0d",
				got.frame_address, got.texel_face, got.texel_x, got.texel_y,
				got.texel_present);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		skya_pkg::texel_out_t want;
		if (!arst_n) begin
			sky_on     = 1'b0;
			face_mask  = '0;
			row_pitch  = 13'd640;
			horizon_q4 = 3840;
			proj_scale = 5120;
			tex_w      = 11'd256;
			tex_h      = 11'd256;
			texel_due.delete();
		end else begin
			// results leave before new pixels are predicted; order does not matter here
			if (out_valid && out_ready) begin
				texels_seen++;
				if (texel_due.size() == 0) begin
					note_failure("texel with nothing expected", '0, out_data);
				end else begin
					want = texel_due.pop_front();
					if (want.frame_address !== out_data.frame_address ||
					    want.texel_face !== out_data.texel_face ||
					    want.texel_x !== out_data.texel_x ||
					    want.texel_y !== out_data.texel_y ||
					    want.texel_present !== out_data.texel_present)
						note_failure("texel mismatch", want, out_data);
				end
			end
			if (in_valid && in_ready) begin
				pixels_taken++;
				if (sky_on) texel_due.push_back(texel_for_pixel(in_data));
			end
			if (cfg_valid && cfg_ready) begin
				case (skya_pkg::reg_idx_t'(cfg_index))
					skya_pkg::REG_SKYBOX_ENABLED:    sky_on     = cfg_data[0];
					skya_pkg::REG_FACE_PRESENT_MASK: face_mask  = cfg_data[5:0];
					skya_pkg::REG_SCREEN_WIDTH:      row_pitch  = cfg_data[12:0];
					skya_pkg::REG_HORIZON_ROW:
						horizon_q4 = longint'($signed(cfg_data[16:0]));
					skya_pkg::REG_PROJECTION_SCALE:  proj_scale = longint'(cfg_data[15:0]);
					skya_pkg::REG_TEXTURE_WIDTH:     tex_w      = cfg_data[10:0];
					skya_pkg::REG_TEXTURE_HEIGHT:    tex_h      = cfg_data[10:0];
					default: ;
				endcase
			end
		end
		texels_waiting = texel_due.size();
	end

	initial begin
		failures       = 0;
		texels_waiting = 0;
		pixels_taken   = 0;
		texels_seen    = 0;
	end

endmodule

// ===== bench/skybox_texel_address_tb.sv =====
// top of the skybox texel address bench: clock, reset, pixel and config stimulus,
// receiver stalls and the verdict; depends on skya_pkg and skybox_texel_address_checker
module skybox_texel_address_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	skya_pkg::pix_in_t               in_data;
	logic                            out_valid;
	logic                            out_ready;
	skya_pkg::texel_out_t            out_data;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [2:0]                      cfg_index;
	logic [skya_pkg::CFG_DATA_W-1:0] cfg_data;

	int failures, texels_waiting, pixels_taken, texels_seen;
	int burst_left;
	int settings_run;
	bit long_hold_req;

	skybox_texel_address dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	skybox_texel_address_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures), .texels_waiting(texels_waiting),
		.pixels_taken(pixels_taken), .texels_seen(texels_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("skybox_texel_address_tb: errors");
		$finish;
	end

	// receiver: random stall styles, plus a long hold-off on request
	initial begin
		int hold_left, run, style;
		hold_left = 0;
		run       = 0;
		style     = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 300;
				out_ready <= 1'b0;
			end else begin
				if (run == 0) begin
					style = $urandom_range(0, 3);
					run   = $urandom_range(10, 150);
				end
				run--;
				case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic write_reg(input skya_pkg::reg_idx_t idx,
		input logic [skya_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// wait for the pipe to empty, including pixels dropped while disabled
	task automatic settle();
		int guard;
		guard = 0;
		while (texels_waiting != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (30) @(posedge clk);
	endtask

	task automatic load_settings(input logic enable, input logic [5:0] mask,
		input logic [12:0] width, input logic [16:0] horizon, input logic [15:0] scale,
		input logic [10:0] tw, input logic [10:0] th);
		settle();
		write_reg(skya_pkg::REG_SKYBOX_ENABLED, 17'(enable));
		write_reg(skya_pkg::REG_FACE_PRESENT_MASK, 17'(mask));
		write_reg(skya_pkg::REG_SCREEN_WIDTH, 17'(width));
		write_reg(skya_pkg::REG_HORIZON_ROW, horizon);
		write_reg(skya_pkg::REG_PROJECTION_SCALE, 17'(scale));
		write_reg(skya_pkg::REG_TEXTURE_WIDTH, 17'(tw));
		write_reg(skya_pkg::REG_TEXTURE_HEIGHT, 17'(th));
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// sender: bursts of random length, with idle gaps of random length between them
	task automatic send_pixel(input skya_pkg::pix_in_t px);
		int gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(60, 120);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	// half the rows land near the horizon so all three bands get hit
	task automatic send_random(input int count, input int horizon_px);
		skya_pkg::pix_in_t px;
		int r;
		for (int i = 0; i < count; i++) begin
			px.pixel_column = 12'($urandom_range(0, 4095));
			px.view_angle   = 16'($urandom());
			if ($urandom_range(0, 1) == 0) begin
				r = horizon_px + $urandom_range(0, 160) - 80;
				if (r < 0) r = 0;
				if (r > 4095) r = 4095;
				px.pixel_row = 12'(r);
			end else begin
				px.pixel_row = 12'($urandom_range(0, 4095));
			end
			send_pixel(px);
		end
		in_valid <= 1'b0;
	endtask

	task automatic send_directed();
		logic [15:0] angles [10] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd8192,
			16'd24576, 16'd40960, 16'd57344, 16'd65535, 16'd64};
		logic [11:0] rows [5] = '{12'd0, 12'd4095, 12'd240, 12'd12, 12'd239};
		skya_pkg::pix_in_t px;
		for (int i = 0; i < 20; i++) begin
			px.view_angle   = angles[i % 10];
			px.pixel_row    = rows[i % 5];
			px.pixel_column = (i % 2 == 1) ? 12'd4095 : 12'd0;
			send_pixel(px);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		int guard;
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		burst_left    = 0;
		settings_run  = 0;
		long_hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults, all faces present
		load_settings(1'b1, 6'h3F, 13'd640, 17'd3840, 16'd5120, 11'd256, 11'd256);
		send_directed();
		long_hold_req = 1'b1;
		send_random(280, 240);

		// disabled: pixels are taken but give nothing
		load_settings(1'b0, 6'h3F, 13'd640, 17'd3840, 16'd5120, 11'd256, 11'd256);
		send_random(50, 240);

		// tiny band, two-by-two textures, half the faces missing
		load_settings(1'b1, 6'h15, 13'd4096, 17'd0, 16'd1, 11'd2, 11'd2);
		send_directed();
		send_random(180, 0);

		// horizon far above the screen, widest scale, largest textures
		load_settings(1'b1, 6'h2A, 13'd1, 17'h10000, 16'd65535, 11'd1024, 11'd1024);
		send_random(180, 0);

		// saturated width and texture height, degenerate texture width, horizon far below
		load_settings(1'b1, 6'h3F, 13'd8191, 17'd65535, 16'd300, 11'd0, 11'd2047);
		long_hold_req = 1'b1;
		send_random(180, 4095);

		// mid screen horizon, one texel wide
		load_settings(1'b1, 6'h3F, 13'd320, 17'd1600, 16'd2000, 11'd1, 11'd64);
		send_random(250, 100);

		guard = 0;
		while (texels_waiting != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
		$display("run covered %0d settings, %0d pixels taken, %0d texels checked",
			settings_run, pixels_taken, texels_seen);
		$display("left waiting %0d, failures %0d", texels_waiting, failures);
		if (failures == 0 && texels_waiting == 0) begin
			$display("skybox_texel_address_tb: clean");
		end else begin
			$display("skybox_texel_address_tb: errors");
		end
		$finish;
	end

endmodule
